### rtl/ffbp_pkg.sv
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants for the first-fit bin packer cell chain.
// ----------------------------------------------------------------------------
package ffbp_pkg;

    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned BIN_IDX_W   = 6;
    localparam int unsigned BINS_USED_W = 7;
    localparam logic [SIZE_W-1:0] CAP_RESET = 16'd1000;

    // Search token that walks the cell chain, one cell per clock.
    typedef struct packed {
        logic              live;       // still looking for a bin
        logic              placed;     // a cell took the item
        logic              opened;     // the taking cell was opened by it
        logic [SIZE_W-1:0] size;       // item size
        logic [SIZE_W-1:0] fresh_room; // room of a newly opened bin after the item
        logic [SIZE_W-1:0] left;       // room left in the chosen bin
    } tok_t;

endpackage

### rtl/ffbp_cell.sv
// ----------------------------------------------------------------------------
// ffbp_cell
// One bin of the chain: holds its open flag and remaining room, serves the
// passing token and hands it on to the next cell.
// ----------------------------------------------------------------------------
module ffbp_cell
    import ffbp_pkg::*;
#(
    parameter int NUM_BINS = 64,
    parameter int CELL_IDX = 0,
    localparam int IDX_W   = $clog2(NUM_BINS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear_all,
    input  logic             in_vld,
    input  tok_t             in_tok,
    input  logic [IDX_W-1:0] in_idx,
    output logic             out_vld,
    output tok_t             out_tok,
    output logic [IDX_W-1:0] out_idx
);

    logic              open_reg, open_next;
    logic [SIZE_W-1:0] room_reg, room_next;
    logic              vld_reg, vld_next;
    tok_t              tok_reg, tok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    always_comb begin
        open_next = open_reg;
        room_next = room_reg;
        vld_next  = in_vld;
        tok_next  = in_tok;
        idx_next  = in_idx;
        if (clear_all) begin
            open_next = 1'b0;
        end else if (in_vld && in_tok.live) begin
            if (open_reg) begin
                if (room_reg >= in_tok.size) begin
                    room_next       = room_reg - in_tok.size;
                    tok_next.live   = 1'b0;
                    tok_next.placed = 1'b1;
                    tok_next.left   = room_reg - in_tok.size;
                    idx_next        = IDX_W'(CELL_IDX);
                end
            end else begin
                // first closed bin: open it for this item
                open_next       = 1'b1;
                room_next       = in_tok.fresh_room;
                tok_next.live   = 1'b0;
                tok_next.placed = 1'b1;
                tok_next.opened = 1'b1;
                tok_next.left   = in_tok.fresh_room;
                idx_next        = IDX_W'(CELL_IDX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end else begin
            open_reg <= open_next;
            vld_reg  <= vld_next;
        end
        room_reg <= room_next;
        tok_reg  <= tok_next;
        idx_reg  <= idx_next;
    end

    assign out_vld = vld_reg;
    assign out_tok = tok_reg;
    assign out_idx = idx_reg;

endmodule

### rtl/first_fit_bin_packer_core.sv
// ----------------------------------------------------------------------------
// first_fit_bin_packer_core
// Online first-fit bin packer built as a chain of NUM_BINS bin cells.
// ----------------------------------------------------------------------------
// Each accepted item becomes a token that walks the bin cells one cell per
// clock; the first open cell with enough room, or else the first closed cell,
// takes it. One item is in flight at a time: the token passes the entry
// register and every cell register, and its result is then registered in the
// output register. The input side reopens once the token leaves the last
// cell, unless the holding slot is full. A finished result waits in an output
// register (plus one holding slot), so the input side reopens while it is
// unclaimed. Bins need no clearing pass: new_set drops every open flag at once.
// ----------------------------------------------------------------------------
module first_fit_bin_packer_core
    import ffbp_pkg::*;
#(
    parameter int NUM_BINS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // bin_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] item_size
    input  logic [0:0]  s_axis_tuser,   // [0] new_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] bin_index, [21:6] space_left,
                                        // [28:22] bins_used, [31:29] zero
    output logic [0:0]  m_axis_tuser    // [0] placed
);

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(NUM_BINS + 1);

    typedef struct packed {
        logic                   placed;
        logic [BIN_IDX_W-1:0]   bin_index;
        logic [SIZE_W-1:0]      space_left;
        logic [BINS_USED_W-1:0] bins_used;
    } res_t;

    logic [SIZE_W-1:0] cap_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              busy_reg;
    logic              out_vld_reg, skid_vld_reg;
    res_t              out_reg, skid_reg, res_new;

    logic             chain_vld [NUM_BINS+1];
    tok_t             chain_tok [NUM_BINS+1];
    logic [IDX_W-1:0] chain_idx [NUM_BINS+1];

    logic             entry_vld_reg;
    tok_t             entry_tok_reg;

    logic s_accept, m_pop, exit_vld, clear_all;
    logic [IDX_W+BIN_IDX_W-1:0]   idx_ext;
    logic [CNT_W+BINS_USED_W-1:0] cnt_ext;

    assign s_axis_tready = !busy_reg && !skid_vld_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_pop         = out_vld_reg && m_axis_tready;
    assign clear_all     = s_accept && s_axis_tuser[0];
    assign exit_vld      = chain_vld[NUM_BINS];

    assign chain_vld[0] = entry_vld_reg;
    assign chain_tok[0] = entry_tok_reg;
    assign chain_idx[0] = '0;

    for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
        ffbp_cell #(
            .NUM_BINS (NUM_BINS),
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear_all (clear_all),
            .in_vld    (chain_vld[i]),
            .in_tok    (chain_tok[i]),
            .in_idx    (chain_idx[i]),
            .out_vld   (chain_vld[i+1]),
            .out_tok   (chain_tok[i+1]),
            .out_idx   (chain_idx[i+1])
        );
    end

    // Result of the token leaving the chain
    always_comb begin
        count_next = count_reg + CNT_W'(chain_tok[NUM_BINS].opened);
        idx_ext    = {{BIN_IDX_W{1'b0}}, chain_idx[NUM_BINS]};
        cnt_ext    = {{BINS_USED_W{1'b0}}, count_next};
        res_new.placed     = chain_tok[NUM_BINS].placed;
        res_new.bin_index  = chain_tok[NUM_BINS].placed ? idx_ext[BIN_IDX_W-1:0] : '0;
        res_new.space_left = chain_tok[NUM_BINS].placed ? chain_tok[NUM_BINS].left : '0;
        res_new.bins_used  = cnt_ext[BINS_USED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            entry_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            entry_vld_reg <= s_accept;
            if (s_accept) begin
                busy_reg <= 1'b1;
                if (s_axis_tuser[0]) begin
                    count_reg <= '0;
                end
            end else if (exit_vld) begin
                busy_reg  <= 1'b0;
                count_reg <= count_next;
            end
            if (exit_vld) begin
                if (!out_vld_reg || m_pop) begin
                    out_vld_reg <= 1'b1;
                end else begin
                    skid_vld_reg <= 1'b1;
                end
            end else if (m_pop) begin
                // refill from the holding slot, or drain
                out_vld_reg  <= skid_vld_reg;
                skid_vld_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            entry_tok_reg.live       <= s_axis_tdata <= cap_reg;
            entry_tok_reg.placed     <= 1'b0;
            entry_tok_reg.opened     <= 1'b0;
            entry_tok_reg.size       <= s_axis_tdata;
            entry_tok_reg.fresh_room <= cap_reg - s_axis_tdata;
            entry_tok_reg.left       <= '0;
        end
        if (exit_vld) begin
            if (!out_vld_reg || m_pop) begin
                out_reg <= res_new;
            end else begin
                skid_reg <= res_new;
            end
        end else if (m_pop && skid_vld_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_reg.placed;
    assign m_axis_tdata  = {3'b000, out_reg.bins_used, out_reg.space_left, out_reg.bin_index};

endmodule

### rtl/ffbp_checker.sv
// ----------------------------------------------------------------------------
// ffbp_checker
// Port-level checks for the first-fit bin packer, bound to the top level.
// ----------------------------------------------------------------------------
module ffbp_checker #(
    parameter int NUM_BINS = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A rejected item reports neither a bin nor any room
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[21:0] == 22'd0))
        else $error("rejected item carries nonzero bin_index or space_left");

    // A placed item sits in one of the open bins
    a_bin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (NUM_BINS <= 64 && m_axis_tvalid && m_axis_tuser[0]) |->
        ({1'b0, m_axis_tdata[5:0]} < m_axis_tdata[28:22]))
        else $error("placed bin_index not below bins_used");

    // One item in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in the chain");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind first_fit_bin_packer_core ffbp_checker #(
    .NUM_BINS (NUM_BINS)
) u_ffbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/first_fit_bin_packer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bin_packer_core_tb
// Self-checking bench for the first-fit bin packer core. It drives item
// transactions and bin capacity writes. A scoreboard class keeps its own copy
// of the bin rooms and the open count, predicts every result and compares it
// field by field with each result transaction. The bench runs several
// capacities and handshake pressure patterns.
// ----------------------------------------------------------------------------
module first_fit_bin_packer_core_tb;
    import ffbp_pkg::*;

    localparam int NUM_BINS    = 64;
    localparam int CLK_HALF    = 2;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 40;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 52;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                   placed;
        logic [BIN_IDX_W-1:0]   bin_index;
        logic [SIZE_W-1:0]      space_left;
        logic [BINS_USED_W-1:0] bins_used;
    } packing_t;

    class bin_scoreboard;
        logic [SIZE_W-1:0] capacity;
        logic [SIZE_W-1:0] room [NUM_BINS];
        int                open_count;
        packing_t          expected_q [$];
        int                errors;
        int                shown;

        function new();
            capacity   = CAP_RESET;
            open_count = 0;
            errors     = 0;
            shown      = 0;
            foreach (room[i]) room[i] = '0;
        endfunction

        function void set_capacity(logic [SIZE_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task flag_mismatch(string what, int got, int want);
            if (shown < MAX_SHOWN) begin
                $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
                shown++;
            end
            errors++;
        endtask

        // First fit: lowest open bin with room, else open the next one.
        function void note_input(logic [SIZE_W-1:0] size, logic fresh);
            packing_t r;
            int       b;
            r = '0;
            if (fresh)
                open_count = 0;
            if (size <= capacity) begin
                for (b = 0; b < open_count && !r.placed; b++) begin
                    if (room[b] >= size) begin
                        room[b]     = room[b] - size;
                        r.placed    = 1'b1;
                        r.bin_index = b[BIN_IDX_W-1:0];
                        r.space_left = room[b];
                    end
                end
                if (!r.placed && open_count < NUM_BINS) begin
                    room[open_count] = capacity - size;
                    r.placed     = 1'b1;
                    r.bin_index  = open_count[BIN_IDX_W-1:0];
                    r.space_left = room[open_count];
                    open_count++;
                end
            end
            r.bins_used = open_count[BINS_USED_W-1:0];
            expected_q.push_back(r);
        endfunction

        task check_result(logic placed, logic [BIN_IDX_W-1:0] bin_index,
                          logic [SIZE_W-1:0] space_left,
                          logic [BINS_USED_W-1:0] bins_used, logic [2:0] pad);
            packing_t want;
            if (expected_q.size() == 0) begin
                flag_mismatch("unexpected result, placed", placed, 0);
            end else begin
                want = expected_q.pop_front();
                if (placed !== want.placed)
                    flag_mismatch("placed", placed, want.placed);
                if (bin_index !== want.bin_index)
                    flag_mismatch("bin_index", bin_index, want.bin_index);
                if (space_left !== want.space_left)
                    flag_mismatch("space_left", space_left, want.space_left);
                if (bins_used !== want.bins_used)
                    flag_mismatch("bins_used", bins_used, want.bins_used);
                if (pad !== 3'b000)
                    flag_mismatch("tdata padding", pad, 0);
            end
        endtask
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    bin_scoreboard sb = new();
    int            cycle_count    = 0;
    int            sender_gap_pct = 0;
    int            recv_stall_pct = 0;
    int            set_left       = 0;

    first_fit_bin_packer_core #(
        .NUM_BINS(NUM_BINS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check results before noting inputs; a result never belongs to this edge's input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser[0], m_axis_tdata[5:0], m_axis_tdata[21:6],
                                m_axis_tdata[28:22], m_axis_tdata[31:29]);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tuser[0]);
        end
    end

    task set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_gap_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_gap_pct = 81;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct = 0;
                recv_stall_pct = 81;
            end
            default: begin
                sender_gap_pct = 27;
                recv_stall_pct = 27;
            end
        endcase
    endtask

    task send_item(logic [15:0] size, logic fresh);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= size;
        s_axis_tuser[0] <= fresh;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Hold off until every outstanding result has come back.
    task wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task write_capacity(logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(value);
    endtask

    function automatic logic [15:0] pick_size(int cap);
        int kind;
        int quarter;
        kind    = $urandom_range(99);
        quarter = (cap / 4 > 1) ? cap / 4 : 1;
        if (kind < 40)
            return 16'($urandom_range(1, quarter));
        else if (kind < 65)
            return 16'($urandom_range(0, cap));
        else if (kind < 75)
            return 16'(cap);
        else if (kind < 80)
            return 16'd0;
        else if (kind < 90)
            return (cap < 65535) ? 16'(cap + 1) : 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    task random_item(int cap);
        logic fresh;
        if (set_left == 0) begin
            set_left = ($urandom_range(3) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 40);
            fresh = ($urandom_range(99) < 90);
        end else begin
            fresh = ($urandom_range(99) < 2);
        end
        set_left--;
        send_item(pick_size(cap), fresh);
    endtask

    initial begin
        int cap_plan [NUM_PHASES];
        int p;
        int cap;

        cap_plan = '{1000, 1, 65535, 7, 0, 0, 300, 0};
        cap_plan[5] = $urandom_range(1, 65535);
        cap_plan[7] = $urandom_range(1, 65535);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sweep at the reset capacity.
        set_idle(IDLE_NONE);
        send_item(16'd0, 1'b1);
        send_item(16'd0, 1'b0);
        send_item(16'd1000, 1'b0);
        send_item(16'd1001, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd600, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'd400, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'd1, 1'b0);
        wait_drained();

        // Raise capacity while bins stay open.
        write_capacity(16'hFFFF);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd999, 1'b0);
        send_item(16'h5555, 1'b1);
        send_item(16'hAAAA, 1'b0);
        wait_drained();

        write_capacity(16'd0);
        send_item(16'd0, 1'b1);
        send_item(16'd1, 1'b0);
        send_item(16'd0, 1'b0);
        wait_drained();

        // Open every bin, then overflow.
        write_capacity(16'd1);
        send_item(16'd1, 1'b1);
        repeat (NUM_BINS - 1) send_item(16'd1, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd2, 1'b0);
        send_item(16'd0, 1'b0);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            cap = cap_plan[p];
            write_capacity(cap[15:0]);
            set_idle(idle_mode_t'(p % 4));
            repeat (PHASE_ITEMS) random_item(cap);
            wait_drained();
        end

        set_idle(IDLE_NONE);
        repeat (NUM_BINS + 10) @(posedge aclk);
        if (sb.pending() != 0)
            sb.flag_mismatch("results outstanding at end", 0, sb.pending());
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### first_fit_bin_packer_core.f
rtl/ffbp_pkg.sv
rtl/ffbp_cell.sv
rtl/first_fit_bin_packer_core.sv
rtl/ffbp_checker.sv
tb/first_fit_bin_packer_core_tb.sv
